[src/rfcm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfcm_pkg: shared constants and helpers for the reader frame checker
// Frame codes, store geometry, card register indexes and reset values, and
// the ASCII hex digit decoder.
// ----------------------------------------------------------------------------
package rfcm_pkg;

	// Frame delimiters.
	localparam logic [7:0] STX_CODE = 8'h02;
	localparam logic [7:0] ETX_CODE = 8'h03;

	// Frame store geometry: fifteen bytes, write index wraps after the last.
	localparam int STORE_DEPTH = 15;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(STORE_DEPTH - 1);

	// Number bytes in a frame and the position of the checksum digits.
	localparam int NUM_BYTES = 5;
	localparam int SUM_POS = 2 * NUM_BYTES + 1;
	localparam int NUM_W = 8 * NUM_BYTES;

	// Card registers: compared slots and configurable ones.
	localparam int CARD_SLOTS = 4;
	localparam int CFG_REGS = 4;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CARD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARD_3 = 3'd3;

	typedef logic [NUM_W-1:0] card_t;

	// Reset value of a card slot; slots without a register stay at zero.
	function automatic card_t card_reset(input logic [CFG_IDX_W-1:0] idx);
		card_t v;
		case (idx)
			REG_CARD_0: v = 40'h2200B28663;
			REG_CARD_1: v = 40'h2200B276C7;
			REG_CARD_2: v = 40'h07005437A7;
			REG_CARD_3: v = 40'h07005437A5;
			default:    v = '0;
		endcase
		return v;
	endfunction

	// Value of one ASCII hex digit; anything other than 0-9 or A-F gives zero.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		v = 4'h0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h41:8'h46]}) begin
			v = 4'(c - 8'h37);
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[src/rfid_frame_check_and_match.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfid_frame_check_and_match: serial reader frame parser and card matcher
// Collects STX, ten number digits, two checksum digits and ETX into a
// wrapping frame store, and on ETX reports the card number, its checksum
// status and the first card register that holds the same number.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-----------------------------------------
//  input   | in_valid / in_ready   | rx_byte
//  result  | out_valid / out_ready | card_number, sent_checksum,
//          |                       | checksum_ok, card_found, card_index
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is accepted in every cycle unless the input stalls. The byte in
// the input register drives the store update, hex decode, checksum and the
// parallel card compares; its result is registered in the output register
// when the byte moves on. Reset clears the store, the index, the receiving
// flag and loads the card reset values. The input stalls only while a
// result waits in the output register and the byte in the input register
// would make another. Configuration writes are always taken.

module rfid_frame_check_and_match
	import rfcm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [NUM_W-1:0]          card_number,
	output logic [7:0]                sent_checksum,
	output logic                      checksum_ok,
	output logic                      card_found,
	output logic [1:0]                card_index,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [NUM_W-1:0]     cfg_data
);

	// Input register.
	logic              valid_s1;
	logic [7:0]        byte_s1;

	// Frame state and card registers.
	logic [7:0]        store_q [STORE_DEPTH];
	logic [IDX_W-1:0]  widx_q;
	logic              recv_q;
	card_t             cards_q [CARD_SLOTS];

	// Output register.
	logic              out_valid_q;
	card_t             number_q;
	logic [7:0]        sum_q;
	logic              ok_q;
	logic              found_q;
	logic [1:0]        index_q;

	// Combinational view of the byte in the input register.
	logic              is_stx;
	logic              recv_eff;
	logic [IDX_W-1:0]  widx_eff;
	logic [IDX_W-1:0]  widx_nxt;
	logic              emit;
	logic              advance;
	logic [7:0]        view [STORE_DEPTH];
	card_t             number_d;
	logic [7:0]        xsum_d;
	logic [7:0]        sum_d;
	logic              found_d;
	logic [1:0]        index_d;

	// Store update for the byte in the input register.
	always_comb begin
		is_stx   = (byte_s1 == STX_CODE);
		recv_eff = is_stx || recv_q;
		widx_eff = is_stx ? '0 : widx_q;
		if (recv_eff) begin
			widx_nxt = (widx_eff == LAST_POS) ? '0 : widx_eff + IDX_W'(1);
		end else begin
			widx_nxt = widx_q;
		end
		emit = (byte_s1 == ETX_CODE) && (widx_nxt != '0);
		for (int i = 0; i < STORE_DEPTH; i++) begin
			view[i] = (recv_eff && (widx_eff == IDX_W'(i))) ? byte_s1 : store_q[i];
		end
	end

	// Hex decode of the number, checksum and byte XOR from the updated store.
	always_comb begin
		number_d = '0;
		xsum_d   = '0;
		for (int i = 0; i < NUM_BYTES; i++) begin
			number_d = {number_d[NUM_W-9:0],
				hex_val(view[2*i+1]), hex_val(view[2*i+2])};
			xsum_d   = xsum_d ^ {hex_val(view[2*i+1]), hex_val(view[2*i+2])};
		end
		sum_d = {hex_val(view[SUM_POS]), hex_val(view[SUM_POS+1])};
	end

	// Card compares; the lowest matching slot wins.
	always_comb begin
		found_d = 1'b0;
		index_d = 2'd0;
		for (int i = CARD_SLOTS - 1; i >= 0; i--) begin
			if (cards_q[i] == number_d) begin
				found_d = 1'b1;
				index_d = 2'(i);
			end
		end
	end

	// Handshake: the input register moves on unless its result is blocked.
	assign advance   = valid_s1 && (!out_valid_q || out_ready || !emit);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			recv_q <= 1'b0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (advance) begin
			widx_q <= widx_nxt;
			recv_q <= recv_eff && !emit;
			if (recv_eff) begin
				store_q[widx_eff] <= byte_s1;
			end
		end
	end

	// Card registers; slots without a register hold their reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CARD_SLOTS; i++) begin
				cards_q[i] <= card_reset(CFG_IDX_W'(i));
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < CARD_SLOTS; i++) begin
				if (i < CFG_REGS && cfg_index == CFG_IDX_W'(i)) begin
					cards_q[i] <= cfg_data;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			number_q <= number_d;
			sum_q    <= sum_d;
			ok_q     <= (sum_d == xsum_d) && (sum_d != 8'h00);
			found_q  <= found_d;
			index_q  <= index_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign card_number   = number_q;
	assign sent_checksum = sum_q;
	assign checksum_ok   = ok_q;
	assign card_found    = found_q;
	assign card_index    = index_q;

endmodule
`default_nettype wire

[src/rfcm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rfcm_checker: port-level checks for the reader frame checker
// Watches the result channel for stalls and for consistency between the
// reported number, checksum and match fields.
// ----------------------------------------------------------------------------
module rfcm_checker
	import rfcm_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [NUM_W-1:0]     card_number,
	input wire logic [7:0]           sent_checksum,
	input wire logic                 checksum_ok,
	input wire logic                 card_found,
	input wire logic [1:0]           card_index
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A good checksum is never zero.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_ok |-> sent_checksum != 8'h00)
		else $error("checksum reported good while zero");

	// A good checksum matches the XOR of the number bytes.
	a_ok_xor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && checksum_ok |-> sent_checksum == (card_number[39:32]
			^ card_number[31:24] ^ card_number[23:16] ^ card_number[15:8]
			^ card_number[7:0]))
		else $error("checksum reported good but differs from byte XOR");

	// Without a match the slot index reads zero.
	a_index_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !card_found |-> card_index == 2'd0)
		else $error("card index nonzero without a match");

endmodule

bind rfid_frame_check_and_match rfcm_checker u_rfcm_checker (.*);
`default_nettype wire

[bench/rfid_frame_check_and_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_frame_check_and_match_test: self-checking bench for the frame checker
// Feeds reader bytes through the input channel, mirrors the frame store and
// card registers in a scoreboard, and compares every reported card number,
// checksum verdict and match against the mirror. Card registers are changed
// between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rfid_frame_check_and_match_test;
	import rfcm_pkg::*;

	localparam int FRAME_LEN = SUM_POS + 3;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 120000;
	localparam int LONG_HOLD_AT = 40;
	localparam int LONG_HOLD = 400;

	// One decoded frame report, as the result channel carries it.
	typedef struct packed {
		card_t      number;
		logic [7:0] checksum;
		logic       sum_ok;
		logic       found;
		logic [1:0] slot;
	} card_report_t;

	// Mirror of the frame store and card registers, and the reports it expects.
	class frame_scoreboard;
		logic [7:0]   store [STORE_DEPTH];
		int unsigned  windex;
		bit           receiving;
		card_t        cards [CARD_SLOTS];
		card_report_t awaited [$];
		int unsigned  mismatches;
		int unsigned  reports;
		int unsigned  card_hits;
		int unsigned  good_sums;

		function new();
			card_t defaults [4];
			defaults = '{40'h2200B28663, 40'h2200B276C7, 40'h07005437A7, 40'h07005437A5};
			foreach (store[i]) store[i] = 8'h00;
			windex = 0;
			receiving = 1'b0;
			for (int i = 0; i < CARD_SLOTS; i++) begin
				cards[i] = (i < CFG_REGS) ? defaults[i] : '0;
			end
			mismatches = 0;
			reports = 0;
			card_hits = 0;
			good_sums = 0;
		endfunction

		// Registers without a configurable slot ignore writes.
		function void load_card(int idx, card_t value);
			if (idx < CFG_REGS && idx < CARD_SLOTS) begin
				cards[idx] = value;
			end
		endfunction

		// Only upper-case hex digits carry a value; anything else counts as zero.
		function logic [3:0] digit_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) begin
				return c[3:0];
			end
			if (c >= 8'h41 && c <= 8'h46) begin
				return 4'(c - 8'h41 + 8'd10);
			end
			return 4'h0;
		endfunction

		// Advance the mirror by one accepted byte and queue any report it causes.
		function void take_byte(logic [7:0] b);
			card_report_t r;
			logic [7:0]   v;
			logic [7:0]   xsum;
			if (b == STX_CODE) begin
				windex = 0;
				receiving = 1'b1;
			end
			if (receiving) begin
				store[windex] = b;
				windex = (windex == STORE_DEPTH - 1) ? 0 : windex + 1;
			end
			if (b != ETX_CODE || windex == 0) begin
				return;
			end
			receiving = 1'b0;
			r.number = '0;
			xsum = 8'h00;
			for (int i = 0; i < NUM_BYTES; i++) begin
				v = {digit_value(store[2 * i + 1]), digit_value(store[2 * i + 2])};
				r.number = {r.number[NUM_W-9:0], v};
				xsum ^= v;
			end
			r.checksum = {digit_value(store[SUM_POS]), digit_value(store[SUM_POS + 1])};
			r.sum_ok = (r.checksum == xsum) && (r.checksum != 8'h00);
			r.found = 1'b0;
			r.slot = 2'd0;
			// Walk downwards so that the lowest matching slot wins.
			for (int i = CARD_SLOTS - 1; i >= 0; i--) begin
				if (cards[i] == r.number) begin
					r.found = 1'b1;
					r.slot = 2'(i);
				end
			end
			awaited.push_back(r);
		endfunction

		// Compare one accepted report with the oldest one expected.
		function void check_result(card_report_t got);
			card_report_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] unexpected report: num %h sum %h ok %b hit %b slot %0d",
						$time, got.number, got.checksum, got.sum_ok, got.found, got.slot);
				end
				return;
			end
			want = awaited.pop_front();
			reports++;
			if (want.found) card_hits++;
			if (want.sum_ok) good_sums++;
			if (got.number !== want.number || got.checksum !== want.checksum ||
					got.sum_ok !== want.sum_ok || got.found !== want.found ||
					got.slot !== want.slot) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] exp/act num %h/%h sum %h/%h ok %b/%b hit %b/%b slot %0d/%0d",
						$time, want.number, got.number, want.checksum, got.checksum,
						want.sum_ok, got.sum_ok, want.found, got.found, want.slot, got.slot);
				end
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [NUM_W-1:0]     card_number;
	logic [7:0]           sent_checksum;
	logic                 checksum_ok;
	logic                 card_found;
	logic [1:0]           card_index;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NUM_W-1:0]     cfg_data;

	frame_scoreboard sb;
	logic [7:0]      frame_buf [FRAME_LEN];
	int unsigned     bytes_sent;
	int unsigned     reg_writes;
	int unsigned     cycles;
	bit              sender_tight;

	rfid_frame_check_and_match dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.card_number  (card_number),
		.sent_checksum(sent_checksum),
		.checksum_ok  (checksum_ok),
		.card_found   (card_found),
		.card_index   (card_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 500 MHz clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic card_t random_card();
		return {8'($urandom_range(0, 255)), 32'($urandom())};
	endfunction

	function automatic logic [7:0] xor_bytes(card_t n);
		logic [7:0] x;
		x = 8'h00;
		for (int i = 0; i < NUM_BYTES; i++) begin
			x ^= n[8 * i +: 8];
		end
		return x;
	endfunction

	function automatic logic [7:0] ascii_digit(logic [3:0] nib, bit lower);
		if (nib < 4'd10) begin
			return 8'h30 + 8'(nib);
		end
		return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
	endfunction

	// Lay out a complete frame: STX, ten number digits, two checksum digits, ETX.
	function automatic void fill_frame(card_t number, logic [7:0] sum, bit lower);
		logic [7:0] b;
		frame_buf[0] = STX_CODE;
		for (int i = 0; i < NUM_BYTES; i++) begin
			b = number[NUM_W - 1 - 8 * i -: 8];
			frame_buf[2 * i + 1] = ascii_digit(b[7:4], lower);
			frame_buf[2 * i + 2] = ascii_digit(b[3:0], lower);
		end
		frame_buf[SUM_POS] = ascii_digit(sum[7:4], lower);
		frame_buf[SUM_POS + 1] = ascii_digit(sum[3:0], lower);
		frame_buf[FRAME_LEN - 1] = ETX_CODE;
	endfunction

	// Offer one byte request after a random gap and wait until it is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0) sender_tight = !sender_tight;
		gap = sender_tight ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_run(input int first, input int count);
		for (int i = first; i < first + count; i++) begin
			send_byte(frame_buf[i]);
		end
	endtask

	// One random frame or fragment: mostly well-formed frames, the rest the
	// awkward shapes a noisy serial line produces.
	task automatic send_random_frame();
		int         kind;
		int         n;
		card_t      number;
		logic [7:0] sum;
		logic [7:0] stray;
		kind = $urandom_range(0, 99);
		number = ($urandom_range(0, 9) < 4) ? sb.cards[$urandom_range(0, CARD_SLOTS - 1)]
			: random_card();
		sum = xor_bytes(number);
		if (kind < 50) begin
			// Well-formed frame, sometimes with a wrong checksum.
			if ($urandom_range(0, 4) == 0) sum = 8'($urandom_range(0, 255));
			fill_frame(number, sum, 1'b0);
			send_run(0, FRAME_LEN);
		end else if (kind < 56) begin
			// Bytes that cancel out, so a zero checksum matches the XOR.
			if ($urandom_range(0, 2) == 0) begin
				number = '0;
			end else begin
				number[7:0] = 8'h00;
				number[7:0] = xor_bytes(number);
			end
			fill_frame(number, 8'h00, 1'b0);
			send_run(0, FRAME_LEN);
		end else if (kind < 62) begin
			// Lower-case letters decode as zero.
			fill_frame(number, sum, 1'b1);
			send_run(0, FRAME_LEN);
		end else if (kind < 68) begin
			// One digit replaced by a random byte other than STX or ETX.
			do stray = 8'($urandom_range(0, 255));
			while (stray == STX_CODE || stray == ETX_CODE);
			fill_frame(number, sum, 1'b0);
			frame_buf[$urandom_range(1, SUM_POS + 1)] = stray;
			send_run(0, FRAME_LEN);
		end else if (kind < 75) begin
			// Early ETX: the rest of the store is left from earlier frames.
			n = $urandom_range(0, SUM_POS);
			fill_frame(number, sum, 1'b0);
			send_run(0, n + 1);
			send_byte(ETX_CODE);
		end else if (kind < 81) begin
			// Overlong frame; one extra digit puts the ETX on the wrap.
			n = $urandom_range(0, 1) ? 1 : $urandom_range(0, 6);
			fill_frame(number, sum, 1'b0);
			send_run(0, FRAME_LEN - 1);
			repeat (n) send_byte(ascii_digit(4'($urandom_range(0, 15)), 1'b0));
			send_byte(ETX_CODE);
		end else if (kind < 88) begin
			// Lone ETX, which repeats the last decode if the index allows.
			send_byte(ETX_CODE);
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int unsigned until_bytes);
		while (bytes_sent < until_bytes) send_random_frame();
	endtask

	// Let every expected report drain and the input register empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves the write request raised; the caller drops it after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input card_t value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.load_card(idx, value);
		reg_writes++;
	endtask

	// Result side: random stalls per report, one long hold to back the block up.
	initial begin : result_sink
		int           stall_left;
		int           taken;
		bit           tight;
		card_report_t got;
		stall_left = 0;
		taken = 0;
		tight = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.number = card_number;
				got.checksum = sent_checksum;
				got.sum_ok = checksum_ok;
				got.found = card_found;
				got.slot = card_index;
				sb.check_result(got);
				taken++;
				if (taken == LONG_HOLD_AT) begin
					stall_left = LONG_HOLD;
				end else begin
					stall_left = tight ? 0 : $urandom_range(0, 3);
				end
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if ($urandom_range(0, 39) == 0) tight = !tight;
			out_ready <= (stall_left == 0);
		end
	end

	// Stimulus: reset values first, then three register settings.
	initial begin : stimulus
		card_t dup;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bytes_sent = 0;
		reg_writes = 0;
		sender_tight = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ETX with an empty index, extreme bytes while idle, a clean
		// frame for the first reset card, a repeated decode, and short frames
		// with a lone digit and with lower-case against upper-case letters.
		send_byte(ETX_CODE);
		send_byte(8'h00);
		send_byte(8'hFF);
		fill_frame(sb.cards[0], xor_bytes(sb.cards[0]), 1'b0);
		send_run(0, FRAME_LEN);
		send_byte(ETX_CODE);
		send_byte(STX_CODE);
		send_byte(8'h31);
		send_byte(ETX_CODE);
		send_byte(STX_CODE);
		send_byte(8'h66);
		send_byte(8'h46);
		send_byte(ETX_CODE);
		run_random(280);
		settle();

		// Random card numbers, plus a write to an index with no register.
		write_reg(REG_CARD_0, random_card());
		write_reg(REG_CARD_1, random_card());
		write_reg(REG_CARD_2, random_card());
		write_reg(REG_CARD_3, random_card());
		write_reg(CFG_IDX_W'($urandom_range(CFG_REGS, (1 << CFG_IDX_W) - 1)), random_card());
		cfg_valid <= 1'b0;
		run_random(560);
		settle();

		// Extremes, and a duplicate pair so the lower slot must win.
		dup = random_card();
		write_reg(REG_CARD_0, '0);
		write_reg(REG_CARD_1, '1);
		write_reg(REG_CARD_2, dup);
		write_reg(REG_CARD_3, dup);
		write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
		cfg_valid <= 1'b0;
		run_random(840);
		settle();

		// Extremes swapped round, duplicate in the two lowest slots.
		dup = random_card();
		write_reg(REG_CARD_0, dup);
		write_reg(REG_CARD_1, dup);
		write_reg(REG_CARD_2, '1);
		write_reg(REG_CARD_3, '0);
		write_reg(CFG_IDX_W'(CFG_REGS), '0);
		cfg_valid <= 1'b0;
		run_random(1100);
		settle();

		$display("Sent %0d bytes over four card settings (%0d register writes).",
			bytes_sent, reg_writes);
		$display("Checked %0d reports: %0d card matches, %0d good checksums, %0d mismatches.",
			sb.reports, sb.card_hits, sb.good_sums, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[rfid_frame_check_and_match.f]
src/rfcm_pkg.sv
src/rfid_frame_check_and_match.sv
src/rfcm_checker.sv
bench/rfid_frame_check_and_match_test.sv
